@@ design/epp_pkg.sv @@
// Shared types and constants for the event packet parser.
// Used by epp_parser, epp_rsp_fifo and event_packet_parser; no dependencies.
package epp_pkg;

   // Header byte bit positions.
   localparam int HDR_P_BIT = 7;
   localparam int HDR_F_BIT = 6;
   localparam int HDR_D_BIT = 5;
   localparam int HDR_T_BIT = 4;

   // Packed response data width: 83 bits of fields rounded up to whole bytes.
   localparam int RSP_FIELD_BITS = 83;
   localparam int RSP_TDATA_W    = 88;

   // Default depth of the response queue.
   localparam int RSP_DEPTH_DEFAULT = 2;

   typedef struct packed {
      logic [31:0] element_key;
      logic [31:0] element_payload;
      logic        payload_present;
      logic [15:0] pkt_prefix;
      logic [1:0]  packet_tag;
      logic        last_element;
      logic        parse_error;
   } rsp_type;

endpackage

@@ design/event_packet_parser.sv @@
// Event packet parser: one packet byte per request in, one element per response out.
// An element's response is written into the queue as its last byte is accepted and offered from the queue head.
// Throughput: one request per cycle while the queue has room; the parser updates its state on the accepting edge.
// Response backpressure is absorbed by a queue of RSP_DEPTH entries before req_tready falls.
// Reset is synchronous and active high: the parser waits for a packet start, the queue empties.
// Depends on epp_pkg, epp_parser and epp_rsp_fifo.
module event_packet_parser #(
   parameter int RSP_DEPTH = epp_pkg::RSP_DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // Request channel.
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,  // [7:0] data_byte
   input  logic [0:0]                      req_tuser,  // [0] packet_start
   // Response channel.
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [31:0] element_key, [63:32] element_payload, [64] payload_present,
   // [80:65] pkt_prefix, [82:81] packet_tag, [87:83] zero
   output logic [epp_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast,  // last_element
   output logic [0:0]                      rsp_tuser   // [0] parse_error
);

   logic             req_accept;
   logic             fifo_full;
   logic             parsed_valid;
   epp_pkg::rsp_type parsed_rsp;
   epp_pkg::rsp_type head_rsp;

   // A request is taken whenever the queue has room for the response it may cause.
   assign req_tready = !fifo_full;
   assign req_accept = req_tvalid && req_tready;

   // The parser holds the phase, counters and field accumulators and builds
   // a response on the byte that completes an element or on a header byte that signals a parse error.
   epp_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .in_accept (req_accept),
      .in_byte   (req_tdata),
      .in_start  (req_tuser[0]),
      .out_valid (parsed_valid),
      .out_rsp   (parsed_rsp)
   );

   // The queue registers each response and keeps the request side moving
   // while the consumer stalls, until the queue is full.
   epp_rsp_fifo #(
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (parsed_valid),
      .push_data (parsed_rsp),
      .full      (fifo_full),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (head_rsp)
   );

   // Pack the response fields, lowest field first, zero padded to whole bytes.
   assign rsp_tdata = {
      (epp_pkg::RSP_TDATA_W - epp_pkg::RSP_FIELD_BITS)'(0),
      head_rsp.packet_tag,
      head_rsp.pkt_prefix,
      head_rsp.payload_present,
      head_rsp.element_payload,
      head_rsp.element_key
   };
   assign rsp_tlast    = head_rsp.last_element;
   assign rsp_tuser[0] = head_rsp.parse_error;

endmodule

@@ design/epp_parser.sv @@
// Byte-wise packet parser: phase register, field accumulators and result build.
// Depends on epp_pkg for the header bit positions and the result struct.
module epp_parser (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_accept,
   input  logic [7:0]       in_byte,
   input  logic             in_start,
   output logic             out_valid,
   output epp_pkg::rsp_type out_rsp
);

   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_HEADER  = 3'd1;
   localparam logic [2:0] PH_PREFIX  = 3'd2;
   localparam logic [2:0] PH_PPREFIX = 3'd3;
   localparam logic [2:0] PH_KEY     = 3'd4;
   localparam logic [2:0] PH_PAYLOAD = 3'd5;
   localparam logic [2:0] PH_DISCARD = 3'd6;

   logic [2:0]  phase_ff, phase_in;
   logic [7:0]  left_ff, left_in;
   logic [2:0]  idx_ff, idx_in;
   logic [1:0]  etype_ff, etype_in;
   logic [4:0]  flags_ff, flags_in;     // P, D, T, tag[1:0]
   logic [15:0] prefix_ff, prefix_in;
   logic [31:0] pprefix_ff, pprefix_in;
   logic [31:0] key_ff, key_in;
   logic [31:0] pay_ff, pay_in;

   logic [31:0] byte_shifted;
   logic [15:0] byte_shifted16;
   logic [2:0]  idx_inc;
   logic [2:0]  key_len;
   logic [2:0]  pp_len;
   logic [7:0]  left_dec;
   logic        emit;
   logic        err;
   logic        pay_on;
   logic        has_stamp;
   logic        hdr_p;
   logic        hdr_f;
   logic        hdr_d;

   assign byte_shifted   = {24'd0, in_byte} << {idx_ff[1:0], 3'b000};
   assign byte_shifted16 = {8'd0, in_byte} << {idx_ff[0], 3'b000};
   assign idx_inc        = idx_ff + 3'd1;
   assign key_len        = etype_ff[1] ? 3'd4 : 3'd2;
   assign pp_len         = (etype_ff == 2'd1) ? 3'd2 : 3'd4;
   assign left_dec       = left_ff - 8'd1;
   assign pay_on         = etype_ff[0];
   assign has_stamp      = !etype_ff[0] && flags_ff[2];
   assign hdr_p          = in_byte[epp_pkg::HDR_P_BIT];
   assign hdr_f          = in_byte[epp_pkg::HDR_F_BIT];
   assign hdr_d          = in_byte[epp_pkg::HDR_D_BIT];

   always_comb begin
      phase_in   = phase_ff;
      left_in    = left_ff;
      idx_in     = idx_ff;
      etype_in   = etype_ff;
      flags_in   = flags_ff;
      prefix_in  = prefix_ff;
      pprefix_in = pprefix_ff;
      key_in     = key_ff;
      pay_in     = pay_ff;
      emit       = 1'b0;
      err        = 1'b0;

      if (in_start) begin
         left_in    = in_byte;
         phase_in   = PH_HEADER;
         idx_in     = 3'd0;
         etype_in   = 2'd0;
         flags_in   = 5'd0;
         prefix_in  = 16'd0;
         pprefix_in = 32'd0;
         key_in     = 32'd0;
         pay_in     = 32'd0;
      end else begin
         case (phase_ff)
            PH_HEADER: begin
               etype_in = in_byte[3:2];
               flags_in = {hdr_p, hdr_d, in_byte[epp_pkg::HDR_T_BIT], in_byte[1:0]};
               idx_in   = 3'd0;
               if (!hdr_p && hdr_f) begin
                  phase_in = PH_DISCARD;
                  err      = 1'b1;
               end else if (hdr_p) begin
                  phase_in = PH_PREFIX;
               end else if (hdr_d) begin
                  phase_in = PH_PPREFIX;
               end else begin
                  phase_in = (left_ff == 8'd0) ? PH_IDLE : PH_KEY;
               end
            end
            PH_PREFIX: begin
               prefix_in = prefix_ff | byte_shifted16;
               idx_in    = idx_inc;
               if (idx_inc >= 3'd2) begin
                  idx_in = 3'd0;
                  if (flags_ff[3]) begin
                     phase_in = PH_PPREFIX;
                  end else begin
                     phase_in = (left_ff == 8'd0) ? PH_IDLE : PH_KEY;
                  end
               end
            end
            PH_PPREFIX: begin
               pprefix_in = pprefix_ff | byte_shifted;
               idx_in     = idx_inc;
               if (idx_inc >= pp_len) begin
                  idx_in   = 3'd0;
                  phase_in = (left_ff == 8'd0) ? PH_IDLE : PH_KEY;
               end
            end
            PH_KEY: begin
               key_in = key_ff | byte_shifted;
               idx_in = idx_inc;
               if (idx_inc >= key_len) begin
                  idx_in = 3'd0;
                  if (etype_ff[0]) begin
                     phase_in = PH_PAYLOAD;
                  end else begin
                     emit = 1'b1;
                  end
               end
            end
            PH_PAYLOAD: begin
               pay_in = pay_ff | byte_shifted;
               idx_in = idx_inc;
               if (idx_inc >= key_len) begin
                  emit = 1'b1;
               end
            end
            PH_IDLE, PH_DISCARD: begin
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase

         if (emit) begin
            left_in  = left_dec;
            key_in   = 32'd0;
            pay_in   = 32'd0;
            idx_in   = 3'd0;
            phase_in = (left_dec == 8'd0) ? PH_IDLE : PH_KEY;
         end
      end
   end

   // Result built from the values the element completes with, or an error result with the header's tag.
   always_comb begin
      out_valid = in_accept && (emit || err);
      out_rsp   = '0;
      if (err) begin
         out_rsp.packet_tag  = in_byte[1:0];
         out_rsp.parse_error = 1'b1;
      end else begin
         out_rsp.element_key     = key_in | key_ff;
         out_rsp.element_payload = pay_on ? (pay_ff | byte_shifted) :
                                   (has_stamp ? pprefix_ff : 32'd0);
         out_rsp.payload_present = pay_on || has_stamp;
         out_rsp.pkt_prefix      = prefix_ff;
         out_rsp.packet_tag      = flags_ff[1:0];
         out_rsp.last_element    = (left_dec == 8'd0);
      end
      // The completed key is the accumulator with this byte added when the
      // key itself ends here; after a payload the key is already complete.
      if (!err) begin
         out_rsp.element_key = (phase_ff == PH_KEY) ? (key_ff | byte_shifted) : key_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         left_ff    <= 8'd0;
         idx_ff     <= 3'd0;
         etype_ff   <= 2'd0;
         flags_ff   <= 5'd0;
         prefix_ff  <= 16'd0;
         pprefix_ff <= 32'd0;
         key_ff     <= 32'd0;
         pay_ff     <= 32'd0;
      end else if (in_accept) begin
         phase_ff   <= phase_in;
         left_ff    <= left_in;
         idx_ff     <= idx_in;
         etype_ff   <= etype_in;
         flags_ff   <= flags_in;
         prefix_ff  <= prefix_in;
         pprefix_ff <= pprefix_in;
         key_ff     <= key_in;
         pay_ff     <= pay_in;
      end
   end

endmodule

@@ design/epp_rsp_fifo.sv @@
// Small response queue that decouples the parser from the result consumer.
// Depends on epp_pkg for the result struct.
module epp_rsp_fifo #(
   parameter int DEPTH = epp_pkg::RSP_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  epp_pkg::rsp_type push_data,
   output logic             full,
   output logic             out_valid,
   input  logic             out_ready,
   output epp_pkg::rsp_type out_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   epp_pkg::rsp_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   assign pop       = out_valid && out_ready;
   assign out_valid = (count_ff != '0);
   assign full      = (count_ff == FULL_CNT);
   assign out_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
